@@ rtl/lmb_pkg.sv @@
// Shared types, register indexes and constants for the lamp mode and beacon block.
package lmb_pkg;

  // Field widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned PHASE_W    = 12;
  localparam int unsigned FADE_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Default depth of the queue between front and back
  localparam int unsigned LMB_QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd4;

  // Register reset values
  localparam logic [COUNT_W-1:0] DEBOUNCE_RST = 8'd20;
  localparam logic [LEVEL_W-1:0] LEVEL1_RST   = 8'd15;
  localparam logic [LEVEL_W-1:0] LEVEL2_RST   = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL3_RST   = 8'd40;
  localparam logic [PHASE_W-1:0] PERIOD_RST   = 12'd800;

  // Strobe pattern segment boundaries
  localparam logic [PHASE_W-1:0] PH_FLASH1_END = 12'd60;
  localparam logic [PHASE_W-1:0] PH_GAP_END    = 12'd120;
  localparam logic [PHASE_W-1:0] PH_FLASH2_END = 12'd180;
  localparam logic [PHASE_W-1:0] PH_FADE_END   = 12'd240;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF,
    MODE_BEACON,
    MODE_BOTH,
    MODE_FRONT
  } mode_t;

  typedef enum logic [1:0] {
    SEG_OFF,
    SEG_FULL,
    SEG_FADE
  } seg_t;

  // Classified item handed from front to back
  typedef struct packed {
    mode_t             mode;
    seg_t              seg;
    logic [FADE_W-1:0] fade;
  } lmb_rec_t;

  // Configuration register contents
  typedef struct packed {
    logic [COUNT_W-1:0] debounce;
    logic [LEVEL_W-1:0] level1;
    logic [LEVEL_W-1:0] level2;
    logic [LEVEL_W-1:0] level3;
    logic [PHASE_W-1:0] period;
  } lmb_cfg_t;

endpackage

@@ rtl/lmb_if.sv @@
// Channel interfaces for button ticks, lamp results and configuration writes.
interface lmb_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface lmb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lamp_mode;
  logic       front_back_on;
  logic [7:0] button_brightness;
  logic [7:0] beacon_brightness;

  modport source (output valid, output lamp_mode, output front_back_on,
                  output button_brightness, output beacon_brightness, input ready);
  modport sink (input valid, input lamp_mode, input front_back_on,
                input button_brightness, input beacon_brightness, output ready);
endinterface

interface lmb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/lmb_cfg.sv @@
// Configuration register file written through the configuration channel.
module lmb_cfg (
  input  logic             clk,
  input  logic             rst,
  lmb_cfg_if.sink          cfg,
  output lmb_pkg::lmb_cfg_t regs
);
  import lmb_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register update; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce <= DEBOUNCE_RST;
      regs.level1   <= LEVEL1_RST;
      regs.level2   <= LEVEL2_RST;
      regs.level3   <= LEVEL3_RST;
      regs.period   <= PERIOD_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_DEBOUNCE: regs.debounce <= cfg.data[COUNT_W-1:0];
        REG_LEVEL1:   regs.level1   <= cfg.data[LEVEL_W-1:0];
        REG_LEVEL2:   regs.level2   <= cfg.data[LEVEL_W-1:0];
        REG_LEVEL3:   regs.level3   <= cfg.data[LEVEL_W-1:0];
        REG_PERIOD:   regs.period   <= cfg.data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/lmb_front.sv @@
// Front part: debounces the button, steps the mode and classifies the strobe phase.
module lmb_front (
  input  logic              clk,
  input  logic              rst,
  lmb_in_if.sink            tick,
  input  lmb_pkg::lmb_cfg_t regs,
  input  logic              full,
  output logic              push,
  output lmb_pkg::lmb_rec_t rec
);
  import lmb_pkg::*;

  logic [COUNT_W-1:0] low_count;
  logic [COUNT_W-1:0] low_count_next;
  logic               armed;
  logic               armed_next;
  mode_t              mode;
  mode_t              mode_next;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W:0]   phase_inc;
  logic [PHASE_W-1:0] fade_off;
  logic               beacon_on;
  logic               released;

  assign tick.ready = !full;
  assign push       = tick.valid && tick.ready;
  assign released   = tick.button_level;

  // Debounce counter, arming and mode step on release.
  always_comb begin
    low_count_next = '0;
    armed_next     = armed;
    mode_next      = mode;
    if (released) begin
      if (armed) begin
        armed_next = 1'b0;
        mode_next  = mode_t'(mode + 2'd1);
      end
    end else begin
      low_count_next = (low_count == COUNT_MAX) ? low_count : low_count + 1'b1;
      if (low_count_next > regs.debounce) begin
        armed_next = 1'b1;
      end
    end
  end

  // Phase advances once per accepted item; it wraps once the next value reaches the period.
  assign phase_inc  = {1'b0, phase} + 1'b1;
  assign phase_next = (phase_inc >= {1'b0, regs.period}) ? '0 : phase_inc[PHASE_W-1:0];
  assign fade_off   = phase - PH_FLASH2_END;
  assign beacon_on  = (mode_next == MODE_BEACON) || (mode_next == MODE_BOTH);

  // Classify the phase held at the start of the tick into a pattern segment.
  always_comb begin
    rec.mode = mode_next;
    rec.fade = fade_off[FADE_W-1:0];
    if (!beacon_on) begin
      rec.seg = SEG_OFF;
    end else if (phase < PH_FLASH1_END) begin
      rec.seg = SEG_FULL;
    end else if (phase < PH_GAP_END) begin
      rec.seg = SEG_OFF;
    end else if (phase < PH_FLASH2_END) begin
      rec.seg = SEG_FULL;
    end else if (phase < PH_FADE_END) begin
      rec.seg = SEG_FADE;
    end else begin
      rec.seg = SEG_OFF;
    end
  end

  // State advances once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_count <= '0;
      armed     <= 1'b0;
      mode      <= MODE_OFF;
      phase     <= '0;
    end else if (push) begin
      low_count <= low_count_next;
      armed     <= armed_next;
      mode      <= mode_next;
      phase     <= phase_next;
    end
  end

`ifndef SYNTHESIS
  a_release_steps_mode: assert property (@(posedge clk) disable iff (rst)
    (push && released && armed) |=> (mode == mode_t'($past(mode) + 2'd1)))
    else $error("armed release did not advance the mode");
`endif
endmodule

@@ rtl/lmb_queue.sv @@
// Short queue of classified items between the front and back parts.
module lmb_queue #(
  parameter int unsigned DEPTH = lmb_pkg::LMB_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lmb_pkg::lmb_rec_t wr_data,
  input  logic              pop,
  output lmb_pkg::lmb_rec_t rd_data,
  output logic              full,
  output logic              empty
);
  import lmb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lmb_rec_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == CNT_W'($past(count) + 1'b1)))
    else $error("queue count did not grow on push");
`endif
endmodule

@@ rtl/lmb_back.sv @@
// Back part: turns classified items into lamp levels held in an output register.
module lmb_back (
  input  logic              clk,
  input  logic              rst,
  input  lmb_pkg::lmb_cfg_t regs,
  input  lmb_pkg::lmb_rec_t rec,
  input  logic              empty,
  output logic              pop,
  lmb_out_if.source         lamp
);
  import lmb_pkg::*;

  logic [LEVEL_W-1:0] bright;
  logic [LEVEL_W-1:0] beacon;
  logic [9:0]         fade_prod;
  logic [LEVEL_W-1:0] fade_drop;

  function automatic logic [9:0] fade_prod_hi(input logic [FADE_W-1:0] d);
    fade_prod_hi = {d, 4'b0000};
  endfunction

  assign pop = !empty && (!lamp.valid || lamp.ready);

  // Button level chosen by mode.
  always_comb begin
    unique case (rec.mode)
      MODE_OFF:    bright = '0;
      MODE_BEACON: bright = regs.level1;
      MODE_BOTH:   bright = regs.level2;
      MODE_FRONT:  bright = regs.level3;
      default:     bright = '0;
    endcase
  end

  // Fade drop is offset*255/60, which equals offset*17/4.
  assign fade_prod = {fade_prod_hi(rec.fade)} + 10'(rec.fade);
  assign fade_drop = LEVEL_W'(fade_prod >> 2);

  always_comb begin
    unique case (rec.seg)
      SEG_FULL: beacon = LEVEL_FULL;
      SEG_FADE: beacon = LEVEL_FULL - fade_drop;
      default:  beacon = '0;
    endcase
  end

  // Output register; it reloads whenever the slot is free or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp.valid <= 1'b0;
    end else if (!lamp.valid || lamp.ready) begin
      lamp.valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lamp.lamp_mode         <= rec.mode;
      lamp.front_back_on     <= rec.mode[1];
      lamp.button_brightness <= bright;
      lamp.beacon_brightness <= beacon;
    end
  end

`ifndef SYNTHESIS
  a_beacon_dark: assert property (@(posedge clk) disable iff (rst)
    (lamp.valid && (lamp.lamp_mode == MODE_OFF || lamp.lamp_mode == MODE_FRONT))
      |-> (lamp.beacon_brightness == '0))
    else $error("beacon lit outside the beacon modes");
`endif
endmodule

@@ rtl/lamp_mode_button_and_beacon_strobe.sv @@
// Top level of the lamp mode button and beacon strobe block.
//
//   Channel  Role   Payload
//   tick     sink   button_level (1 = released, 0 = pressed)
//   lamp     source lamp_mode, front_back_on, button_brightness, beacon_brightness
//   cfg      sink   index (register 0..4), data (12 bits, low bits used)
//
// One item is taken per clock cycle while the queue is not full; its result is written into
// the queue, then into the output register, where it waits until the lamp channel accepts it.
// The rate is set by the front state update, which advances once per accepted item.
// Reset (rst, synchronous) clears the counters, mode and phase and loads register defaults.
// A stalled lamp channel fills the queue, and tick.ready drops only when it is full.
// Configuration writes are always taken.
module lamp_mode_button_and_beacon_strobe #(
  parameter int unsigned QUEUE_DEPTH = lmb_pkg::LMB_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  lmb_in_if.sink    tick,
  lmb_out_if.source lamp,
  lmb_cfg_if.sink   cfg
);
  import lmb_pkg::*;

  lmb_cfg_t regs;
  lmb_rec_t wr_rec;
  lmb_rec_t rd_rec;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  lmb_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lmb_front u_front (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .regs (regs),
    .full (full),
    .push (push),
    .rec  (wr_rec)
  );

  lmb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_rec),
    .pop     (pop),
    .rd_data (rd_rec),
    .full    (full),
    .empty   (empty)
  );

  lmb_back u_back (
    .clk   (clk),
    .rst   (rst),
    .regs  (regs),
    .rec   (rd_rec),
    .empty (empty),
    .pop   (pop),
    .lamp  (lamp)
  );
endmodule
